[design/tbum_pkg.sv]
// Package of shared types and constants for the two-bank unaligned byte memory.
`timescale 1ns / 1ps

package tbum_pkg;

  // Byte address width; the memory holds 2**ADDR_BITS bytes.
  localparam int unsigned ADDR_BITS = 8;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned MODE_BITS = 3;
  localparam int unsigned BYTE_BITS = 8;
  // Four byte lanes: lanes 0 and 2 form the even bank, lanes 1 and 3 the odd bank.
  localparam int unsigned LANES     = 4;
  localparam int unsigned LANE_BITS = 2;
  localparam int unsigned ROW_BITS  = ADDR_BITS - LANE_BITS;
  localparam int unsigned LANE_ROWS = 1 << ROW_BITS;
  localparam int unsigned IN_BITS   = 48;

  typedef logic [ROW_BITS-1:0]  row_t;
  typedef logic [BYTE_BITS-1:0] byte_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD_BYTE  = 3'd0,
    MODE_LOAD_HALF  = 3'd1,
    MODE_LOAD_WORD  = 3'd2,
    MODE_STORE_BYTE = 3'd3,
    MODE_STORE_HALF = 3'd4,
    MODE_STORE_WORD = 3'd5
  } mode_e;

  // Access size held as the number of bytes minus one.
  localparam logic [LANE_BITS-1:0] SIZE_BYTE = 2'd0;
  localparam logic [LANE_BITS-1:0] SIZE_HALF = 2'd1;
  localparam logic [LANE_BITS-1:0] SIZE_WORD = 2'd3;

  // Request from the access decoder to one byte lane.
  typedef struct packed {
    logic  en;
    logic  we;
    row_t  row;
    byte_t wdata;
  } lane_req_t;

endpackage

[design/tbum_lane.sv]
// One byte lane of the memory: a row store with per-row written flags and a registered read.
`timescale 1ns / 1ps

module tbum_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbum_pkg::lane_req_t req_i,
  output tbum_pkg::byte_t     rd_data_o
);

  tbum_pkg::byte_t                      mem_q [tbum_pkg::LANE_ROWS];
  logic [tbum_pkg::LANE_ROWS-1:0]       valid_q;
  tbum_pkg::byte_t                      rd_q;

  // Rows never written since reset read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.en && req_i.we) begin
      valid_q[req_i.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.we) begin
      mem_q[req_i.row] <= req_i.wdata;
    end
    if (req_i.en && !req_i.we) begin
      rd_q <= valid_q[req_i.row] ? mem_q[req_i.row] : '0;
    end
  end

  assign rd_data_o = rd_q;

  a_write_marks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.en && req_i.we |=> valid_q[$past(req_i.row)])
    else $error("written row not marked valid");

  a_unwritten_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.en && !req_i.we && !valid_q[req_i.row] |=> rd_data_o == '0)
    else $error("unwritten row did not read as zero");

  a_write_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.we |-> req_i.en)
    else $error("lane write without enable");

endmodule

[design/two_bank_unaligned_byte_memory.sv]
// Top level of the two-bank unaligned byte memory with big-endian byte, half and word access.
//
//   channel   dir  payload                                    completes when
//   s_axis    in   mode, address, write_data                  tvalid && tready
//   m_axis    out  read_data (loads only)                     tvalid && tready
//
// One item is taken in every cycle while the output side keeps up. A load's result passes
// through the registered lane read and then the result register, where the bytes are
// rotated into big-endian order. Stores finish at acceptance.
// Reset clears all written flags at once, so the memory reads as zero straight away.
// A stalled result holds the output register and the read stage behind it; input is
// still taken while the read stage is empty or about to move on.
`timescale 1ns / 1ps

module two_bank_unaligned_byte_memory (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // mode [2:0], address [10:3], write_data [42:11], zero
  input  logic [tbum_pkg::IN_BITS-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata    // read_data [31:0]
);

  logic [tbum_pkg::MODE_BITS-1:0] in_mode;
  logic [tbum_pkg::ADDR_BITS-1:0] in_addr;
  logic [tbum_pkg::DATA_BITS-1:0] in_wdata;
  logic                           accept;
  logic                           is_load;
  logic                           is_store;
  logic [tbum_pkg::LANE_BITS-1:0] size;
  logic                           s1_advance;

  logic                           s1_valid_q, s1_valid_d;
  logic [tbum_pkg::LANE_BITS-1:0] s1_base_q;
  logic [tbum_pkg::LANE_BITS-1:0] s1_size_q;
  logic                           out_valid_q, out_valid_d;
  logic [tbum_pkg::DATA_BITS-1:0] out_data_q, out_data_d;

  tbum_pkg::lane_req_t lane_req [tbum_pkg::LANES];
  tbum_pkg::byte_t     lane_rd  [tbum_pkg::LANES];
  logic [tbum_pkg::LANES-1:0] lane_en;

  assign in_mode  = s_axis_tdata[2:0];
  assign in_addr  = s_axis_tdata[10:3];
  assign in_wdata = s_axis_tdata[42:11];

  always_comb begin
    is_load  = 1'b0;
    is_store = 1'b0;
    size     = tbum_pkg::SIZE_BYTE;
    unique case (in_mode)
      tbum_pkg::MODE_LOAD_BYTE:  begin is_load  = 1'b1; size = tbum_pkg::SIZE_BYTE; end
      tbum_pkg::MODE_LOAD_HALF:  begin is_load  = 1'b1; size = tbum_pkg::SIZE_HALF; end
      tbum_pkg::MODE_LOAD_WORD:  begin is_load  = 1'b1; size = tbum_pkg::SIZE_WORD; end
      tbum_pkg::MODE_STORE_BYTE: begin is_store = 1'b1; size = tbum_pkg::SIZE_BYTE; end
      tbum_pkg::MODE_STORE_HALF: begin is_store = 1'b1; size = tbum_pkg::SIZE_HALF; end
      tbum_pkg::MODE_STORE_WORD: begin is_store = 1'b1; size = tbum_pkg::SIZE_WORD; end
      default: begin
        is_load  = 1'b0;
        is_store = 1'b0;
      end
    endcase
  end

  assign s1_advance    = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Byte j of the access lives in lane (address + j) mod 4, so each lane sees at most
  // one byte and lane L carries byte (L - address) mod 4.
  for (genvar l = 0; l < tbum_pkg::LANES; l++) begin : g_lane
    logic [tbum_pkg::LANE_BITS-1:0] offs;
    logic [tbum_pkg::ADDR_BITS-1:0] byte_addr;
    logic [tbum_pkg::LANE_BITS-1:0] from_lsb;
    logic [tbum_pkg::DATA_BITS-1:0] shifted;

    assign offs      = tbum_pkg::LANE_BITS'(l) - in_addr[tbum_pkg::LANE_BITS-1:0];
    assign byte_addr = in_addr + tbum_pkg::ADDR_BITS'(offs);
    assign from_lsb  = size - offs;
    assign shifted   = in_wdata >> {from_lsb, 3'b000};
    assign lane_en[l] = accept && (is_load || is_store) && (offs <= size);

    assign lane_req[l].en    = lane_en[l];
    assign lane_req[l].we    = lane_en[l] && is_store;
    assign lane_req[l].row   = byte_addr[tbum_pkg::ADDR_BITS-1:tbum_pkg::LANE_BITS];
    assign lane_req[l].wdata = shifted[tbum_pkg::BYTE_BITS-1:0];

    tbum_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .req_i     (lane_req[l]),
      .rd_data_o (lane_rd[l])
    );
  end

  // Gather the bytes most significant first, starting at the lane of the address.
  always_comb begin
    logic [tbum_pkg::LANE_BITS-1:0] sel;
    logic [tbum_pkg::DATA_BITS-1:0] acc;
    acc = '0;
    for (int j = 0; j < tbum_pkg::LANES; j++) begin
      sel = s1_base_q + tbum_pkg::LANE_BITS'(j);
      if (tbum_pkg::LANE_BITS'(j) <= s1_size_q) begin
        acc = {acc[tbum_pkg::DATA_BITS-tbum_pkg::BYTE_BITS-1:0], lane_rd[sel]};
      end
    end
    out_data_d = acc;
  end

  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (s1_advance) begin
      out_valid_d = s1_valid_q;
    end
    if (s_axis_tready) begin
      s1_valid_d = accept && is_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_base_q <= in_addr[tbum_pkg::LANE_BITS-1:0];
      s1_size_q <= size;
    end
    if (s1_advance && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_store_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_load |=> !s1_valid_q)
    else $error("non-load item entered the read stage");

  a_lane_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (is_load || is_store) |-> $countones(lane_en) == 32'(size) + 32'd1)
    else $error("lane enables do not match the access size");

endmodule
